// ===== design/ozmr_pkg.sv =====
// Shared constants and types for the overlap zone median raster.
`timescale 1ns / 1ps
package ozmr_pkg;
  localparam int GRID_SIDE  = 64;
  localparam int SIDE_W     = $clog2(GRID_SIDE);
  localparam int ADDR_W     = 2 * SIDE_W;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int CNT_W      = SIDE_W + 1;
  localparam int CELL_W     = 8;
  localparam int COORD_W    = 31;
  localparam int SIZE_W     = 20;
  localparam int OUT_W      = 33;
  localparam int PROD_W     = SIZE_W + CNT_W;

  localparam logic [CELL_W-1:0] CELL_EMPTY   = 8'h00;
  localparam logic [CELL_W-1:0] CELL_OVERLAP = 8'hFF;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_ROWS     = 3'd3;
  localparam logic [2:0] REG_COLS     = 3'd4;
  localparam logic [2:0] REG_ROW_MODE = 3'd5;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } grid_wr_t;
endpackage

// ===== design/ozmr_div.sv =====
// Bit-serial restoring divider for a cell offset over the cell size.
`timescale 1ns / 1ps
module ozmr_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ozmr_pkg::COORD_W-1:0]    dividend,
  input  logic [ozmr_pkg::SIZE_W-1:0]     divisor,
  output logic                            done,
  output logic [ozmr_pkg::COORD_W-1:0]    quotient
);
  localparam logic [4:0] LAST_STEP = 5'(ozmr_pkg::COORD_W - 1);

  logic [ozmr_pkg::SIZE_W-1:0]  rem_r, rem_nxt;
  logic [ozmr_pkg::COORD_W-1:0] quo_r, quo_nxt;
  logic [ozmr_pkg::SIZE_W-1:0]  dsr_r;
  logic [4:0]                   cnt_r;
  logic                         run_r, done_r;
  logic [ozmr_pkg::SIZE_W:0]    shifted, diff;
  logic                         ge;

  always_comb begin
    shifted = {rem_r, quo_r[ozmr_pkg::COORD_W-1]};
    ge      = shifted >= {1'b0, dsr_r};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = ge ? diff[ozmr_pkg::SIZE_W-1:0] : shifted[ozmr_pkg::SIZE_W-1:0];
    quo_nxt = {quo_r[ozmr_pkg::COORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// ===== design/ozmr_grid.sv =====
// Cell grid memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ozmr_grid (
  input  logic                          clk,
  input  ozmr_pkg::grid_wr_t            wr,
  input  logic [ozmr_pkg::ADDR_W-1:0]   raddr,
  output logic [ozmr_pkg::CELL_W-1:0]   rdata
);
  logic [ozmr_pkg::CELL_W-1:0] mem [ozmr_pkg::GRID_DEPTH];
  logic [ozmr_pkg::CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== design/overlap_zone_median_raster.sv =====
// Top level of the overlap zone median raster.
//
// Command channel: an item is taken when start is high and busy is low.
// command 0 adds a point: the x and y offsets from the origin are divided
// by the cell size in two bit-serial dividers, one quotient bit per cycle,
// then the cell is read and rewritten. Points with line 0 or 255 or
// below or left of the origin are dropped when taken, without a division;
// points beyond the rows or columns in use drop after the division.
// command 1 finishes: each row (or column) is scanned one cell per cycle,
// followed by the tail, median lookup, multiply and output steps; then
// the whole grid memory is cleared, one cell per cycle.
// Results appear one beat at a time, out_valid high for one cycle; the
// receiver cannot stall. last_line marks the final beat of a finish.
// After reset the same clearing pass runs with busy high; configuration
// writes are taken at any time and should only be made while busy is low.
`timescale 1ns / 1ps
module overlap_zone_median_raster (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic signed [ozmr_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [ozmr_pkg::COORD_W-1:0] in_point_y,
  input  logic [7:0]                         in_flight_line,
  output logic                               out_valid,
  output logic signed [ozmr_pkg::OUT_W-1:0]  out_line_centre,
  output logic signed [ozmr_pkg::OUT_W-1:0]  out_median_position,
  output logic [ozmr_pkg::CNT_W-1:0]         out_overlap_count,
  output logic                               out_has_overlap,
  output logic                               out_last_line,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [ozmr_pkg::COORD_W-1:0]       cfg_data
);
  localparam int SW = ozmr_pkg::SIDE_W;
  localparam int CW = ozmr_pkg::CNT_W;
  localparam int AW = ozmr_pkg::ADDR_W;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_RD   = 4'd3;
  localparam logic [3:0] ST_WR   = 4'd4;
  localparam logic [3:0] ST_SCAN = 4'd5;
  localparam logic [3:0] ST_TAIL = 4'd6;
  localparam logic [3:0] ST_H1   = 4'd7;
  localparam logic [3:0] ST_H2   = 4'd8;
  localparam logic [3:0] ST_MUL  = 4'd9;
  localparam logic [3:0] ST_ADD  = 4'd10;

  logic signed [ozmr_pkg::COORD_W-1:0] org_x_r, org_y_r;
  logic [ozmr_pkg::SIZE_W-1:0]         size_r;
  logic [CW-1:0]                       rows_r, cols_r;
  logic                                row_mode_r;

  logic [3:0]    state_r;
  logic [AW-1:0] clr_r;
  logic [7:0]    line_r;
  logic [AW-1:0] addr_r;
  logic [SW-1:0] a_r, b_r;
  logic [CW-1:0] k_r;
  logic          seen_r;
  logic [SW-1:0] hi_r;
  logic [ozmr_pkg::PROD_W-1:0] pmed_r, pcen_r;
  logic          out_valid_r, last_r, has_r;
  logic signed [ozmr_pkg::OUT_W-1:0] cen_r, med_r;
  logic [CW-1:0] cnt_out_r;

  logic [SW-1:0] hit_mem [ozmr_pkg::GRID_SIDE];
  logic [SW-1:0] hit_rd_r;
  logic [SW-1:0] hit_raddr;

  logic [ozmr_pkg::SIZE_W-1:0] eff_size;
  logic [CW-1:0]               nr, nc, outer, inner;
  logic signed [31:0]          offx, offy;
  logic                        drop;
  logic                        accept;
  logic                        qx_done, qy_done;
  logic [ozmr_pkg::COORD_W-1:0] qx, qy;
  logic                        in_range;
  logic [ozmr_pkg::CELL_W-1:0] cell_rd, cell_new;
  logic [AW-1:0]               grid_raddr, scan_addr;
  ozmr_pkg::grid_wr_t          gwr;
  logic                        hit;
  logic [SW-1:0]               lo;
  logic [CW-1:0]               sum_med, sum_cen;
  logic signed [ozmr_pkg::COORD_W-1:0] o_out, o_in;
  logic                        last_a;

  always_comb begin
    eff_size = (size_r == '0) ? ozmr_pkg::SIZE_W'(1) : size_r;
    nr = (rows_r == '0) ? CW'(1) : (rows_r > CW'(ozmr_pkg::GRID_SIDE)) ?
         CW'(ozmr_pkg::GRID_SIDE) : rows_r;
    nc = (cols_r == '0) ? CW'(1) : (cols_r > CW'(ozmr_pkg::GRID_SIDE)) ?
         CW'(ozmr_pkg::GRID_SIDE) : cols_r;
    outer = row_mode_r ? nr : nc;
    inner = row_mode_r ? nc : nr;
    o_out = row_mode_r ? org_y_r : org_x_r;
    o_in  = row_mode_r ? org_x_r : org_y_r;
    offx  = 32'(in_point_x) - 32'(org_x_r);
    offy  = 32'(in_point_y) - 32'(org_y_r);
    drop  = (in_flight_line == ozmr_pkg::CELL_EMPTY) ||
            (in_flight_line == ozmr_pkg::CELL_OVERLAP) || offx[31] || offy[31];
    accept = start && (state_r == ST_IDLE);
    in_range = (qx < ozmr_pkg::COORD_W'(nc)) && (qy < ozmr_pkg::COORD_W'(nr));
    scan_addr = row_mode_r ? {a_r, b_r} : {b_r, a_r};
    grid_raddr = (state_r == ST_SCAN) ? scan_addr : addr_r;
    if (cell_rd == ozmr_pkg::CELL_EMPTY) begin
      cell_new = line_r;
    end else if (cell_rd != line_r) begin
      cell_new = ozmr_pkg::CELL_OVERLAP;
    end else begin
      cell_new = cell_rd;
    end
    gwr.we   = (state_r == ST_CLR) || (state_r == ST_WR);
    gwr.addr = (state_r == ST_CLR) ? clr_r : addr_r;
    gwr.data = (state_r == ST_CLR) ? ozmr_pkg::CELL_EMPTY : cell_new;
    hit = seen_r && (cell_rd == ozmr_pkg::CELL_OVERLAP);
    hit_raddr = (state_r == ST_H2) ? k_r[CW-1:1] - SW'(1) : k_r[CW-1:1];
    lo = k_r[0] ? hi_r : hit_rd_r;
    sum_med = CW'(lo) + CW'(hi_r) + CW'(1);
    sum_cen = {a_r, 1'b1};
    last_a = ({1'b0, a_r} + CW'(1)) == outer;
  end

  ozmr_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(accept && !in_command && !drop),
    .dividend(offx[ozmr_pkg::COORD_W-1:0]), .divisor(eff_size),
    .done(qx_done), .quotient(qx)
  );

  ozmr_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(accept && !in_command && !drop),
    .dividend(offy[ozmr_pkg::COORD_W-1:0]), .divisor(eff_size),
    .done(qy_done), .quotient(qy)
  );

  ozmr_grid u_grid (
    .clk(clk), .wr(gwr), .raddr(grid_raddr), .rdata(cell_rd)
  );

  always_ff @(posedge clk) begin
    if (hit) begin
      hit_mem[k_r[SW-1:0]] <= b_r - SW'(1);
    end
    hit_rd_r <= hit_mem[hit_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r    <= '0;
      org_y_r    <= '0;
      size_r     <= ozmr_pkg::SIZE_W'(1);
      rows_r     <= CW'(ozmr_pkg::GRID_SIDE);
      cols_r     <= CW'(ozmr_pkg::GRID_SIDE);
      row_mode_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ozmr_pkg::REG_ORIGIN_X:  org_x_r    <= cfg_data;
        ozmr_pkg::REG_ORIGIN_Y:  org_y_r    <= cfg_data;
        ozmr_pkg::REG_CELL_SIZE: size_r     <= cfg_data[ozmr_pkg::SIZE_W-1:0];
        ozmr_pkg::REG_ROWS:      rows_r     <= cfg_data[CW-1:0];
        ozmr_pkg::REG_COLS:      cols_r     <= cfg_data[CW-1:0];
        ozmr_pkg::REG_ROW_MODE:  row_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      a_r         <= '0;
      b_r         <= '0;
    end else begin
      seen_r      <= (state_r == ST_SCAN);
      out_valid_r <= 1'b0;
      if (hit) begin
        k_r <= k_r + CW'(1);
      end
      case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(ozmr_pkg::GRID_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_command == ozmr_pkg::CMD_FINISH) begin
              a_r     <= '0;
              b_r     <= '0;
              k_r     <= '0;
              state_r <= ST_SCAN;
            end else if (!drop) begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (qx_done && qy_done) begin
            state_r <= in_range ? ST_RD : ST_IDLE;
          end
        end
        ST_RD:   state_r <= ST_WR;
        ST_WR:   state_r <= ST_IDLE;
        ST_SCAN: begin
          b_r <= b_r + SW'(1);
          if (({1'b0, b_r} + CW'(1)) == inner) begin
            state_r <= ST_TAIL;
          end
        end
        ST_TAIL: state_r <= ST_H1;
        ST_H1:   state_r <= ST_H2;
        ST_H2:   state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_ADD;
        ST_ADD: begin
          out_valid_r <= 1'b1;
          k_r         <= '0;
          b_r         <= '0;
          a_r         <= a_r + SW'(1);
          if (last_a) begin
            clr_r   <= '0;
            state_r <= ST_CLR;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_r <= in_flight_line;
    end
    if (state_r == ST_DIV) begin
      addr_r <= {qy[SW-1:0], qx[SW-1:0]};
    end
    if (state_r == ST_H2) begin
      hi_r <= hit_rd_r;
    end
    if (state_r == ST_MUL) begin
      pmed_r <= eff_size * sum_med;
      pcen_r <= eff_size * sum_cen;
    end
    if (state_r == ST_ADD) begin
      cen_r     <= ozmr_pkg::OUT_W'($signed({o_out, 1'b0})) +
                   ozmr_pkg::OUT_W'(pcen_r);
      med_r     <= (k_r == '0) ? '0 :
                   ozmr_pkg::OUT_W'($signed({o_in, 1'b0})) + ozmr_pkg::OUT_W'(pmed_r);
      cnt_out_r <= k_r;
      has_r     <= (k_r != '0);
      last_r    <= last_a;
    end
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_line_centre     = cen_r;
  assign out_median_position = med_r;
  assign out_overlap_count   = cnt_out_r;
  assign out_has_overlap     = has_r;
  assign out_last_line       = last_r;

`ifndef SYNTHESIS
  a_beat_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_ADD)
    else $error("result beat without output step");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= CW'(ozmr_pkg::GRID_SIDE))
    else $error("overlap count overflow");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> state_r == ST_CLR)
    else $error("no clearing pass after final beat");
  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |=> state_r == ST_IDLE)
    else $error("grid update not closed");
`endif
endmodule
